[src/imu_fp_pkg.sv]
`timescale 1ns / 1ps
// imu_fp_pkg: shared types and constants of the imu frame parser
// no dependencies; imported by the front, queue, back and top modules

package imu_fp_pkg;

   // byte and position widths fixed by the frame format
   localparam int BYTE_W    = 8;
   localparam int POS_W     = 5;
   localparam int FIELD_W   = 16;
   localparam int NUM_FIELDS = 10;
   localparam int RSP_W     = FIELD_W * NUM_FIELDS;

   // frame marker bytes
   localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h7F;
   localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h80;
   localparam logic [BYTE_W-1:0] CHK_BASE   = 8'hFF;

   // what the front end hands the back end
   typedef enum logic {
      TOK_DATA,
      TOK_CHECK
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type          kind;
      logic [POS_W-1:0]      pos;
      logic [BYTE_W-1:0]     data;
   } token_type;

endpackage

[src/imu_fp_front.sv]
`timescale 1ns / 1ps
// imu_fp_front: header hunt and byte classification of the imu frame parser
// depends on imu_fp_pkg; pushes classified bytes into imu_fp_queue

module imu_fp_front import imu_fp_pkg::*; #(
   parameter int PAYLOAD_BYTES = 20
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,
   input  logic              q_full,
   output logic              push,
   output token_type         push_tok
);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_HDR2,
      PH_DATA,
      PH_CHK
   } phase_type;

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(PAYLOAD_BYTES - 1);

   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             accept;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (req_tdata == HDR_FIRST) phase_in = PH_HDR2;
            end
            PH_HDR2: begin
               // a wrong second byte is consumed, never retried as a header
               if (req_tdata == HDR_SECOND) begin
                  phase_in = PH_DATA;
                  pos_in   = '0;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_DATA: begin
               if (pos_ff == LAST_POS) begin
                  phase_in = PH_CHK;
                  pos_in   = '0;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
            PH_CHK: begin
               phase_in = PH_HUNT;
               pos_in   = '0;
            end
            default: phase_in = PH_HUNT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         pos_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
      end
   end

   assign push          = accept && (phase_ff == PH_DATA || phase_ff == PH_CHK);
   assign push_tok.kind = (phase_ff == PH_CHK) ? TOK_CHECK : TOK_DATA;
   assign push_tok.pos  = pos_ff;
   assign push_tok.data = req_tdata;

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> pos_ff <= LAST_POS)
      else $error("payload position past the end of the frame");

   a_check_follows_last: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_DATA && pos_ff == LAST_POS |=> phase_ff == PH_CHK)
      else $error("last payload byte not followed by checksum phase");

   a_hunt_pushes_nothing: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HUNT || phase_ff == PH_HDR2) |-> !push)
      else $error("header byte pushed into queue");

endmodule

[src/imu_fp_queue.sv]
`timescale 1ns / 1ps
// imu_fp_queue: two-entry token queue between front and back of the parser
// depends on imu_fp_pkg for token_type

module imu_fp_queue import imu_fp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  token_type push_tok,
   output logic      full,
   input  logic      pop,
   output logic      pop_valid,
   output token_type pop_tok
);

   localparam int DEPTH = 2;

   token_type                    tok_ff [DEPTH];
   logic [$clog2(DEPTH)-1:0]     wr_ptr_ff;
   logic [$clog2(DEPTH)-1:0]     rd_ptr_ff;
   logic [$clog2(DEPTH+1)-1:0]   count_ff;

   assign full      = (count_ff == ($clog2(DEPTH+1))'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_tok   = tok_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) tok_ff[wr_ptr_ff] <= push_tok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full token queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("pop from empty token queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ($clog2(DEPTH+1))'(DEPTH))
      else $error("token queue count out of range");

endmodule

[src/imu_fp_back.sv]
`timescale 1ns / 1ps
// imu_fp_back: payload store, running sum, checksum test and result register
// depends on imu_fp_pkg; drains tokens from imu_fp_queue

module imu_fp_back import imu_fp_pkg::*; #(
   parameter int PAYLOAD_BYTES = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  token_type        q_tok,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata
);

   localparam int IDX_W = $clog2(PAYLOAD_BYTES);

   logic [BYTE_W-1:0] store_ff [PAYLOAD_BYTES];
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic              rsp_valid_ff;
   logic [RSP_W-1:0]  rsp_data_ff;
   logic [RSP_W-1:0]  frame_word;
   logic              is_data, is_check, sum_ok, load;

   assign is_data  = q_valid && q_tok.kind == TOK_DATA;
   assign is_check = q_valid && q_tok.kind == TOK_CHECK;
   // data tokens always drain; a check token waits for a free result slot
   assign pop      = is_data || (is_check && (!rsp_valid_ff || rsp_tready));
   assign sum_ok   = ((CHK_BASE - sum_ff) == q_tok.data);
   assign load     = pop && is_check && sum_ok;

   // first payload byte restarts the sum
   assign sum_in = (q_tok.pos == '0) ? q_tok.data : sum_ff + q_tok.data;

   always_ff @(posedge clock) begin
      if (is_data) begin
         store_ff[q_tok.pos[IDX_W-1:0]] <= q_tok.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) sum_ff <= '0;
      else if (is_data) sum_ff <= sum_in;
   end

   // bytes beyond the payload length read as zero
   for (genvar b = 0; b < 2 * NUM_FIELDS; b++) begin : g_byte
      if (b < PAYLOAD_BYTES) begin : g_live
         assign frame_word[b*BYTE_W +: BYTE_W] = store_ff[b];
      end else begin : g_zero
         assign frame_word[b*BYTE_W +: BYTE_W] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) rsp_data_ff <= frame_word;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_check_waits_for_slot: assert property (@(posedge clock) disable iff (reset)
      pop && is_check |-> !rsp_valid_ff || rsp_tready)
      else $error("check token drained over an untaken result");

   a_sum_restart: assert property (@(posedge clock) disable iff (reset)
      is_data && q_tok.pos == '0 |=> sum_ff == $past(q_tok.data))
      else $error("running sum not restarted at first payload byte");

   a_load_needs_match: assert property (@(posedge clock) disable iff (reset)
      load |-> is_check && sum_ok)
      else $error("result loaded without a passing checksum");

endmodule

[src/imu_frame_parser_top.sv]
`timescale 1ns / 1ps
// imu_frame_parser_top: top level of the imu serial frame parser
// depends on imu_fp_pkg, imu_fp_front, imu_fp_queue and imu_fp_back
//
//   channel   dir   handshake              payload
//   req_      in    req_tvalid/tready      req_tdata[7:0]   received serial byte
//   rsp_      out   rsp_tvalid/tready      rsp_tdata[159:0] ten 16-bit raw fields
//
// one byte per cycle is taken while the token queue has room; the front end
// classifies it in the cycle it arrives and the back end drains one token per cycle
// while no checksum token waits for a free result slot
// a frame result is valid from the edge its checksum byte, once written into the queue, leaves it
// reset is synchronous and active high; it returns the parser to header hunting
// a stalled rsp_ side holds only checksum transactions; payload bytes keep draining,
// so the input stalls only once the two-entry queue fills behind a pending result

module imu_frame_parser_top import imu_fp_pkg::*; #(
   parameter int PAYLOAD_BYTES = 20
) (
   input  logic              clock,
   input  logic              reset,
   // req_tdata: rx_byte[7:0]
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,
   // rsp_tdata: accel_x_raw[15:0], accel_y_raw[31:16], accel_z_raw[47:32],
   //            rate_x_raw[63:48], rate_y_raw[79:64], rate_z_raw[95:80],
   //            roll_raw[111:96], pitch_raw[127:112], yaw_raw[143:128],
   //            temperature_raw[159:144]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata
);

   // front to queue
   logic      push;
   token_type push_tok;
   logic      q_full;
   // queue to back
   logic      pop;
   logic      q_valid;
   token_type q_tok;

   // header hunt, payload position count
   imu_fp_front #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .push       (push),
      .push_tok   (push_tok)
   );

   // decouples byte intake from result delivery
   imu_fp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_tok  (push_tok),
      .full      (q_full),
      .pop       (pop),
      .pop_valid (q_valid),
      .pop_tok   (q_tok)
   );

   // payload store, checksum and result register
   imu_fp_back #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_tok      (q_tok),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[bench/tb_imu_frame_parser_top.sv]
`timescale 1ns / 1ps
// tb_imu_frame_parser_top: self-checking bench for the imu serial frame parser
// depends on imu_fp_pkg and imu_frame_parser_top; bytes in, predicted frames checked out

module tb_imu_frame_parser_top;
   import imu_fp_pkg::*;

   localparam int PAYLOAD_LEN  = 20;
   localparam int RANDOM_ITEMS = 1230;
   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CAP    = 2000;

   // parser sync phases as the predictor tracks them
   typedef enum logic [1:0] {
      SYNC_HUNT,
      SYNC_SECOND,
      SYNC_COLLECT,
      SYNC_CHECK
   } sync_phase_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [BYTE_W-1:0] req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;

   // predictor state
   sync_phase_type    sync_phase = SYNC_HUNT;
   int unsigned       byte_pos = 0;
   logic [BYTE_W-1:0] payload_sum = '0;
   logic [BYTE_W-1:0] payload_bytes [32];
   logic [RSP_W-1:0]  pending_frames [$];

   bit steady = 1'b0;        // no idling on either side while set
   int items_sent = 0;
   int fail_count = 0;
   int idle_cycles = 0;
   int hold_left = 0;

   string field_names [NUM_FIELDS] = '{
      "accel_x_raw", "accel_y_raw", "accel_z_raw", "rate_x_raw", "rate_y_raw",
      "rate_z_raw", "roll_raw", "pitch_raw", "yaw_raw", "temperature_raw"
   };

   imu_frame_parser_top #(.PAYLOAD_BYTES(PAYLOAD_LEN)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // payload byte biased toward the marker values and the extremes
   function automatic logic [BYTE_W-1:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return HDR_FIRST;
         1: return HDR_SECOND;
         2: return $urandom_range(0, 1) ? 8'h00 : 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // advance the parser prediction by one accepted byte
   task automatic predict_byte(input logic [BYTE_W-1:0] rx);
      logic [RSP_W-1:0] frame;
      logic [BYTE_W-1:0] lo;
      logic [BYTE_W-1:0] hi;
      case (sync_phase)
         SYNC_HUNT: begin
            if (rx == HDR_FIRST) sync_phase = SYNC_SECOND;
         end
         SYNC_SECOND: begin
            // a wrong second byte is consumed, even a new 0x7F
            if (rx == HDR_SECOND) begin
               sync_phase  = SYNC_COLLECT;
               byte_pos    = 0;
               payload_sum = '0;
            end else begin
               sync_phase = SYNC_HUNT;
            end
         end
         SYNC_COLLECT: begin
            payload_bytes[byte_pos % 32] = rx;
            payload_sum = payload_sum + rx;
            if (byte_pos + 1 >= PAYLOAD_LEN) begin
               byte_pos   = 0;
               sync_phase = SYNC_CHECK;
            end else begin
               byte_pos = byte_pos + 1;
            end
         end
         default: begin
            if (CHK_BASE - payload_sum == rx) begin
               for (int k = 0; k < NUM_FIELDS; k++) begin
                  lo = (2 * k < PAYLOAD_LEN) ? payload_bytes[2 * k] : 8'h00;
                  hi = (2 * k + 1 < PAYLOAD_LEN) ? payload_bytes[2 * k + 1] : 8'h00;
                  frame[k * FIELD_W +: FIELD_W] = {hi, lo};
               end
               pending_frames.push_back(frame);
            end
            sync_phase = SYNC_HUNT;
            byte_pos   = 0;
         end
      endcase
   endtask

   // one byte transaction on req_, called and returning at a falling edge
   task automatic send_byte(input logic [BYTE_W-1:0] rx);
      int gap;
      req_tvalid = 1'b1;
      req_tdata  = rx;
      do @(posedge clock); while (!req_tready);
      predict_byte(rx);
      items_sent++;
      @(negedge clock);
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // header, payload and checksum; corrupt flips checksum bits
   task automatic send_frame(input bit corrupt);
      logic [BYTE_W-1:0] body [PAYLOAD_LEN];
      logic [BYTE_W-1:0] sum;
      sum = '0;
      for (int i = 0; i < PAYLOAD_LEN; i++) begin
         body[i] = pick_byte();
         sum = sum + body[i];
      end
      send_byte(HDR_FIRST);
      send_byte(HDR_SECOND);
      foreach (body[i]) send_byte(body[i]);
      send_byte((CHK_BASE - sum) ^ (corrupt ? 8'($urandom_range(1, 255)) : 8'h00));
   endtask

   // doubled header byte is consumed, so the following 0x80 is just noise;
   // then a clean frame carrying the extremes of every payload bit
   task automatic test_header_resync();
      logic [BYTE_W-1:0] body [PAYLOAD_LEN] = '{
         8'h00, 8'hFF, 8'h7F, 8'h80, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20,
         8'h40, 8'h80, 8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hDF, 8'hBF, 8'h7F
      };
      logic [BYTE_W-1:0] sum;
      sum = '0;
      send_byte(HDR_FIRST);
      send_byte(HDR_FIRST);
      send_byte(HDR_SECOND);
      send_byte(HDR_FIRST);
      send_byte(HDR_SECOND);
      foreach (body[i]) begin
         send_byte(body[i]);
         sum = sum + body[i];
      end
      send_byte(CHK_BASE - sum);
   endtask

   // full-rate frames with the result side always ready
   task automatic test_back_to_back();
      steady = 1'b1;
      repeat (4) send_frame(1'b0);
      steady = 1'b0;
   endtask

   // mostly good frames, some with bad checksums, some noise and broken headers
   task automatic test_random_traffic();
      int target;
      int roll;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         steady = ($urandom_range(0, 9) == 0);
         roll = $urandom_range(0, 99);
         if (roll < 72) begin
            send_frame(1'b0);
         end else if (roll < 86) begin
            send_frame(1'b1);
         end else if (roll < 93) begin
            // header with a random, usually wrong, second byte
            send_byte(HDR_FIRST);
            send_byte(pick_byte());
         end else begin
            repeat ($urandom_range(1, 8)) send_byte(pick_byte());
         end
      end
      steady = 1'b0;
   endtask

   // result-side backpressure
   always @(negedge clock) begin
      if (steady) begin
         hold_left  = 0;
         rsp_tready = 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready = 1'b0;
      end else begin
         hold_left  = pick_gap();
         rsp_tready = (hold_left == 0);
         if (hold_left > 0) hold_left--;
      end
   end

   // compare every rsp_ transaction with the oldest predicted frame
   always @(posedge clock) begin
      logic [RSP_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_frames.size() == 0) begin
            $error("unexpected frame result: %h", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_frames.pop_front();
            for (int k = 0; k < NUM_FIELDS; k++) begin
               if (rsp_tdata[k * FIELD_W +: FIELD_W] !== want[k * FIELD_W +: FIELD_W]) begin
                  $error("%s mismatch: expected %0d, actual %0d", field_names[k],
                         want[k * FIELD_W +: FIELD_W], rsp_tdata[k * FIELD_W +: FIELD_W]);
                  fail_count++;
               end
            end
         end
      end
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int waited;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_header_resync();
      test_back_to_back();
      test_random_traffic();

      req_tvalid = 1'b0;
      waited = 0;
      while (pending_frames.size() != 0 && waited < DRAIN_CAP) begin
         @(posedge clock);
         waited++;
      end
      if (pending_frames.size() != 0) begin
         $error("%0d predicted frames never arrived", pending_frames.size());
         fail_count++;
      end
      repeat (20) @(posedge clock);

      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

[sim.f]
src/imu_fp_pkg.sv
src/imu_fp_front.sv
src/imu_fp_queue.sv
src/imu_fp_back.sv
src/imu_frame_parser_top.sv
bench/tb_imu_frame_parser_top.sv
